### hdl/mlnps_pkg.sv
`timescale 1ns / 1ps

package mlnps_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  // fallback retrigger velocity, 0.7 of full scale rounded
  localparam logic [6:0] FALLBACK_VEL = 7'd89;

  // event kinds
  localparam logic [1:0] KIND_ON      = 2'd0;
  localparam logic [1:0] KIND_OFF     = 2'd1;
  localparam logic [1:0] KIND_ALL_OFF = 2'd2;

  // voice actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUSH,
    ST_TOP,
    ST_TOPWAIT,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] voice_note;
    logic [6:0] voice_velocity;
    logic       fast_release;
    logic [4:0] held_count;
  } result_t;

endpackage

### hdl/mlnps_if.sv
`timescale 1ns / 1ps

interface mlnps_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] note;
  logic [6:0] velocity;

  modport source (output valid, output kind, output note, output velocity, input ready);
  modport sink (input valid, input kind, input note, input velocity, output ready);
endinterface

interface mlnps_voice_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] voice_note;
  logic [6:0] voice_velocity;
  logic       fast_release;
  logic [4:0] held_count;

  modport source (output valid, output action, output voice_note, output voice_velocity,
                  output fast_release, output held_count, input ready);
  modport sink (input valid, input action, input voice_note, input voice_velocity,
                input fast_release, input held_count, output ready);
endinterface

### hdl/mono_last_note_priority_stack_top.sv
`timescale 1ns / 1ps

// monophonic last-note priority stack
// evt channel: one request per MIDI event (kind, note, velocity); a note-on
// with velocity zero counts as a note-off
// voice channel: exactly one result per request (action, voice_note,
// voice_velocity, fast_release, held_count)
// held notes sit in a single-port-write, single-port-read memory; each note
// event does a serial compaction pass over the held entries, one read a cycle
// per request: a note-off runs the scan, then reads the new top entry when
// the sounding note was released and others remain, so the newest held note
// retriggers; a note-on runs the scan, shifts out the oldest entry when the
// stack was full, then pushes; all-notes-off and unknown kinds go straight
// to the result; the compaction scan sets the rate
// a new request is taken once the sequencer is back in idle, even while the
// previous result still waits in the output register
// if the receiver stalls, the result holds in the output register and the
// sequencer waits in its last state until the register frees
// reset (rst, synchronous) empties the stack and marks nothing sounding; the
// memory needs no clearing since only entries below the count are read
module mono_last_note_priority_stack_top #(
  parameter int STACK_DEPTH = mlnps_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mlnps_event_if.sink   evt,
  mlnps_voice_if.source voice
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [6:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [6:0]    ram_rdata;

  mlnps_pkg::result_t res;
  mlnps_pkg::result_t out_res;
  logic               res_valid;
  logic               res_free;
  logic               out_valid;

  // held note storage
  mlnps_ram #(
    .WIDTH (7),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // event sequencer: scan, shift, push and retrigger
  mlnps_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_free  (res_free)
  );

  // output register, free when empty or being drained this cycle
  assign res_free = !out_valid || voice.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid <= 1'b1;
    end else if (voice.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_res <= res;
    end
  end

  assign voice.valid          = out_valid;
  assign voice.action         = out_res.action;
  assign voice.voice_note     = out_res.voice_note;
  assign voice.voice_velocity = out_res.voice_velocity;
  assign voice.fast_release   = out_res.fast_release;
  assign voice.held_count     = out_res.held_count;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_free) |=> voice.valid)
    else $error("result handed over but not presented");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (voice.valid && !voice.ready) |=> voice.valid)
    else $error("result dropped while the receiver stalls");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (voice.valid && !voice.ready) |=> $stable(out_res))
    else $error("result changed while the receiver stalls");

endmodule

### hdl/mlnps_ram.sv
`timescale 1ns / 1ps

module mlnps_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = mlnps_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/mlnps_seq.sv
`timescale 1ns / 1ps

module mlnps_seq #(
  parameter int STACK_DEPTH = mlnps_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  mlnps_event_if.sink                    evt,
  output logic                           ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
  output logic [6:0]                     ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
  input  logic [6:0]                     ram_rdata,
  output mlnps_pkg::result_t             res,
  output logic                           res_valid,
  input  logic                           res_free
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  mlnps_pkg::seq_state_t state, state_next;

  logic [CW-1:0] rd, rd_next;
  logic [CW-1:0] wr, wr_next;
  logic          pend, pend_next;
  logic [CW-1:0] count, count_next;
  logic          snd_valid, snd_valid_next;
  logic [6:0]    snd_note, snd_note_next;
  logic          is_on, is_on_next;
  logic [6:0]    cur_note, cur_note_next;
  logic [6:0]    cur_vel, cur_vel_next;
  mlnps_pkg::result_t res_next;
  logic [CW-1:0] top_idx;
  logic [1:0]    kind_eff;

  assign top_idx = count - ONE_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mlnps_pkg::ST_IDLE;
      pend      <= 1'b0;
      count     <= '0;
      snd_valid <= 1'b0;
      snd_note  <= '0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      count     <= count_next;
      snd_valid <= snd_valid_next;
      snd_note  <= snd_note_next;
    end
  end

  always_ff @(posedge clk) begin
    rd       <= rd_next;
    wr       <= wr_next;
    is_on    <= is_on_next;
    cur_note <= cur_note_next;
    cur_vel  <= cur_vel_next;
    res      <= res_next;
  end

  always_comb begin
    state_next     = state;
    rd_next        = rd;
    wr_next        = wr;
    pend_next      = pend;
    count_next     = count;
    snd_valid_next = snd_valid;
    snd_note_next  = snd_note;
    is_on_next     = is_on;
    cur_note_next  = cur_note;
    cur_vel_next   = cur_vel;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = wr[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = rd[AW-1:0];
    evt.ready      = 1'b0;
    res_valid      = 1'b0;
    kind_eff       = evt.kind;
    if (evt.kind == mlnps_pkg::KIND_ON && evt.velocity == 7'd0) begin
      kind_eff = mlnps_pkg::KIND_OFF;
    end

    unique case (state)
      mlnps_pkg::ST_IDLE: begin
        evt.ready = 1'b1;
        if (evt.valid) begin
          cur_note_next = evt.note;
          cur_vel_next  = evt.velocity;
          rd_next       = '0;
          wr_next       = '0;
          pend_next     = 1'b0;
          unique case (kind_eff) inside
            mlnps_pkg::KIND_ON, mlnps_pkg::KIND_OFF: begin
              is_on_next = (kind_eff == mlnps_pkg::KIND_ON);
              state_next = mlnps_pkg::ST_SCAN;
            end
            mlnps_pkg::KIND_ALL_OFF: begin
              count_next     = '0;
              snd_valid_next = 1'b0;
              snd_note_next  = '0;
              res_next       = '{mlnps_pkg::ACT_STOP, 7'd0, 7'd0, 1'b1, 5'd0};
              state_next     = mlnps_pkg::ST_FINISH;
            end
            default: begin
              res_next   = '{mlnps_pkg::ACT_NONE, 7'd0, 7'd0, 1'b0, 5'(count)};
              state_next = mlnps_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // compact the stack in place, skipping copies of the event note
      mlnps_pkg::ST_SCAN: begin
        if (pend && ram_rdata != cur_note) begin
          ram_we  = 1'b1;
          wr_next = wr + ONE_C;
        end
        if (rd < count) begin
          ram_re    = 1'b1;
          rd_next   = rd + ONE_C;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (rd == count && !pend) begin
          count_next = wr;
          if (is_on) begin
            if (wr == DEPTH_C) begin
              rd_next    = ONE_C;
              wr_next    = '0;
              state_next = mlnps_pkg::ST_SHIFT;
            end else begin
              state_next = mlnps_pkg::ST_PUSH;
            end
          end else if (snd_valid && snd_note == cur_note) begin
            if (wr != '0) begin
              state_next = mlnps_pkg::ST_TOP;
            end else begin
              snd_valid_next = 1'b0;
              snd_note_next  = '0;
              res_next       = '{mlnps_pkg::ACT_STOP, 7'd0, 7'd0, 1'b0, 5'(wr)};
              state_next     = mlnps_pkg::ST_FINISH;
            end
          end else begin
            res_next   = '{mlnps_pkg::ACT_NONE, 7'd0, 7'd0, 1'b0, 5'(wr)};
            state_next = mlnps_pkg::ST_FINISH;
          end
        end
      end

      // full stack: drop the oldest entry, move the rest down
      mlnps_pkg::ST_SHIFT: begin
        if (pend) begin
          ram_we  = 1'b1;
          wr_next = wr + ONE_C;
        end
        if (rd < DEPTH_C) begin
          ram_re    = 1'b1;
          rd_next   = rd + ONE_C;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (rd == DEPTH_C && !pend) begin
          state_next = mlnps_pkg::ST_PUSH;
        end
      end

      mlnps_pkg::ST_PUSH: begin
        ram_we         = 1'b1;
        ram_wdata      = cur_note;
        count_next     = wr + ONE_C;
        snd_valid_next = 1'b1;
        snd_note_next  = cur_note;
        res_next       = '{mlnps_pkg::ACT_START, cur_note, cur_vel, 1'b0, 5'(wr + ONE_C)};
        state_next     = mlnps_pkg::ST_FINISH;
      end

      mlnps_pkg::ST_TOP: begin
        ram_re     = 1'b1;
        ram_raddr  = top_idx[AW-1:0];
        state_next = mlnps_pkg::ST_TOPWAIT;
      end

      mlnps_pkg::ST_TOPWAIT: begin
        snd_note_next = ram_rdata;
        res_next      = '{mlnps_pkg::ACT_START, ram_rdata, mlnps_pkg::FALLBACK_VEL, 1'b0,
                          5'(count)};
        state_next    = mlnps_pkg::ST_FINISH;
      end

      mlnps_pkg::ST_FINISH: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_next = mlnps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mlnps_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("stack memory read and written at one address");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stack count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> (state != mlnps_pkg::ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_silent_note_zero: assert property (@(posedge clk) disable iff (rst)
    !snd_valid |-> (snd_note == 7'd0))
    else $error("sounding note left set while nothing sounds");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == mlnps_pkg::ST_PUSH) |-> (wr < DEPTH_C))
    else $error("push into a full stack");

endmodule
